[sv/erl_pkg.sv]
// Shared types and constants for the envelope linear resampler.
package erl_pkg;

   localparam int HARMONICS = 56;
   localparam int WIN_LEN   = HARMONICS + 4;
   localparam int ADDR_W    = $clog2(HARMONICS);
   localparam int CNT_W     = $clog2(HARMONICS + 1);
   localparam int IDX_W     = 6;
   localparam int VALUE_W   = 16;
   localparam int ACC_W     = 32;
   localparam int FRAC_W    = 15;

   localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(HARMONICS - 1);
   localparam logic [FRAC_W-1:0] WEIGHT_ONE  = 15'h7FFF;
   localparam logic [ACC_W-1:0]  RATIO_UNITY = 32'h0001_0000;

   typedef struct packed {
      logic signed [VALUE_W-1:0] env_value;
      logic [IDX_W-1:0]          env_index;
      logic signed [VALUE_W-1:0] f0_target;
      logic signed [VALUE_W-1:0] f0_source;
      logic [IDX_W-1:0]          out_count;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] out_value;
      logic [IDX_W-1:0]          out_index;
      logic                      out_last;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic [ACC_W-1:0] acc;
      logic [IDX_W-1:0] index;
      logic             last;
   } issue_type;

   typedef struct packed {
      logic             done;
      logic [ACC_W-1:0] ratio;
   } ratio_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RATIO,
      ST_ISSUE,
      ST_DRAIN
   } ctrl_state_type;

   typedef enum logic [2:0] {
      DV_IDLE,
      DV_NORM,
      DV_SETUP,
      DV_ITER,
      DV_FINAL
   } div_state_type;

endpackage

[sv/envelope_linear_resampler_top.sv]
// Envelope linear resampler top level: load control and run sequencer.
// A transfer with index below 55 is stored; busy stays low.
// Index 55 with a nonzero count starts a run: the ratio uses a 32-step serial divide,
// skipped when the operands are equal or the divisor is zero; results follow one per cycle.
// busy is high from the starting transfer until the final result is on the ports.
// Synchronous reset returns to idle with no result pending; store contents are kept.
module envelope_linear_resampler_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  erl_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output erl_pkg::rsp_type rsp_payload
);
   import erl_pkg::*;

   ctrl_state_type   state_ff, state_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] n_ff, n_in;

   logic              accept;
   logic              index_ok;
   logic              run_go;
   logic [CNT_W-1:0]  count_sat;
   ratio_status_type  ratio_status;
   issue_type         issue;
   logic              pipe_busy;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [ADDR_W-1:0] rd_addr_b;
   logic signed [VALUE_W-1:0] rd_data_a;
   logic signed [VALUE_W-1:0] rd_data_b;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign index_ok = {1'b0, req_payload.env_index} < (IDX_W + 1)'(HARMONICS);
   assign count_sat = ({1'b0, req_payload.out_count} > (IDX_W + 1)'(HARMONICS)) ?
                      CNT_W'(HARMONICS) : CNT_W'(req_payload.out_count);
   assign run_go   = accept && index_ok
                     && (req_payload.env_index[ADDR_W-1:0] == LAST_ADDR)
                     && (count_sat != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      acc_ff <= acc_in;
      k_ff   <= k_in;
      n_ff   <= n_in;
   end

   always_comb begin
      state_in    = state_ff;
      acc_in      = acc_ff;
      k_in        = k_ff;
      n_in        = n_ff;
      issue.valid = 1'b0;
      issue.acc   = acc_ff;
      issue.index = IDX_W'(k_ff);
      issue.last  = (k_ff + 1'b1 == n_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (run_go) begin
               n_in     = count_sat;
               state_in = ST_RATIO;
            end
         end
         ST_RATIO: begin
            if (ratio_status.done) begin
               acc_in   = ratio_status.ratio;
               k_in     = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            issue.valid = 1'b1;
            acc_in      = acc_ff + ratio_status.ratio;
            k_in        = k_ff + 1'b1;
            if (issue.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   erl_store u_store (
      .clock     (clock),
      .wr_en     (accept && index_ok),
      .wr_addr   (req_payload.env_index[ADDR_W-1:0]),
      .wr_data   (req_payload.env_value),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   erl_ratio u_ratio (
      .clock  (clock),
      .reset  (reset),
      .go     (run_go),
      .num    (req_payload.f0_target),
      .den    (req_payload.f0_source),
      .status (ratio_status)
   );

   erl_interp u_interp (
      .clock       (clock),
      .reset       (reset),
      .issue       (issue),
      .rd_addr_a   (rd_addr_a),
      .rd_addr_b   (rd_addr_b),
      .rd_data_a   (rd_data_a),
      .rd_data_b   (rd_data_b),
      .pipe_busy   (pipe_busy),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

[sv/erl_store.sv]
// Envelope store: one write port, two registered read ports.
module erl_store (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [erl_pkg::ADDR_W-1:0]         wr_addr,
   input  logic signed [erl_pkg::VALUE_W-1:0] wr_data,
   input  logic [erl_pkg::ADDR_W-1:0]         rd_addr_a,
   input  logic [erl_pkg::ADDR_W-1:0]         rd_addr_b,
   output logic signed [erl_pkg::VALUE_W-1:0] rd_data_a,
   output logic signed [erl_pkg::VALUE_W-1:0] rd_data_b
);
   import erl_pkg::*;

   logic signed [VALUE_W-1:0] mem [HARMONICS];
   logic signed [VALUE_W-1:0] rd_a_ff;
   logic signed [VALUE_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[sv/erl_ratio.sv]
// Q16 ratio unit: normalize divisor, bit-serial restoring divide, re-shift.
module erl_ratio (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               go,
   input  logic signed [erl_pkg::VALUE_W-1:0] num,
   input  logic signed [erl_pkg::VALUE_W-1:0] den,
   output erl_pkg::ratio_status_type          status
);
   import erl_pkg::*;

   div_state_type       state_ff, state_in;
   logic signed [15:0]  num_ff, num_in;
   logic signed [15:0]  den_ff, den_in;
   logic signed [15:0]  nden_ff, nden_in;
   logic [4:0]          lz_ff, lz_in;
   logic [4:0]          sh_ff, sh_in;
   logic                neg_ff, neg_in;
   logic [15:0]         rem_ff, rem_in;
   logic [15:0]         mb_ff, mb_in;
   logic [31:0]         dvd_ff, dvd_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [ACC_W-1:0]    ratio_ff, ratio_in;
   logic                done_ff, done_in;

   logic [15:0] norm_src;
   logic [4:0]  lz_calc;
   logic        lt;
   logic [15:0] mag_num;
   logic [16:0] shifted;
   logic [17:0] diff;
   logic [15:0] qh;
   logic [15:0] q16;
   logic [31:0] v32;
   logic [4:0]  rsh;

   function automatic logic [4:0] clz16(input logic [15:0] x);
      logic [4:0] n;
      n = 5'd16;
      for (int i = 0; i < 16; i++) begin
         if (x[i]) n = 5'(15 - i);
      end
      return n;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      num_ff   <= num_in;
      den_ff   <= den_in;
      nden_ff  <= nden_in;
      lz_ff    <= lz_in;
      sh_ff    <= sh_in;
      neg_ff   <= neg_in;
      rem_ff   <= rem_in;
      mb_ff    <= mb_in;
      dvd_ff   <= dvd_in;
      cnt_ff   <= cnt_in;
      ratio_ff <= ratio_in;
   end

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      nden_in  = nden_ff;
      lz_in    = lz_ff;
      sh_in    = sh_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      mb_in    = mb_ff;
      dvd_in   = dvd_ff;
      cnt_in   = cnt_ff;
      ratio_in = ratio_ff;
      done_in  = 1'b0;

      norm_src = den_ff[15] ? ~den_ff : den_ff;
      lz_calc  = clz16(norm_src);
      lt       = num_ff < nden_ff;
      mag_num  = num_ff[15] ? 16'(-num_ff) : num_ff;
      shifted  = {rem_ff, dvd_ff[31]};
      diff     = {1'b0, shifted} - {2'b00, mb_ff};
      qh       = dvd_ff[16:1];
      q16      = neg_ff ? 16'(-qh) : qh;
      v32      = {q16, 16'h0000};
      rsh      = 5'(-sh_ff);

      unique case (state_ff)
         DV_IDLE: begin
            if (go) begin
               num_in   = num;
               den_in   = den;
               state_in = DV_NORM;
            end
         end
         DV_NORM: begin
            if (num_ff == den_ff) begin
               ratio_in = RATIO_UNITY;
               done_in  = 1'b1;
               state_in = DV_IDLE;
            end else if (den_ff == 16'sd0) begin
               ratio_in = '0;
               done_in  = 1'b1;
               state_in = DV_IDLE;
            end else begin
               lz_in    = lz_calc;
               nden_in  = den_ff << 4'(lz_calc - 5'd1);
               state_in = DV_SETUP;
            end
         end
         DV_SETUP: begin
            sh_in    = 5'(lz_ff - (lt ? 5'd16 : 5'd15));
            dvd_in   = lt ? {mag_num, 16'h0000} : {1'b0, mag_num, 15'h0000};
            mb_in    = nden_ff[15] ? 16'(-nden_ff) : nden_ff;
            neg_in   = num_ff[15] ^ nden_ff[15];
            rem_in   = '0;
            cnt_in   = 5'd31;
            state_in = DV_ITER;
         end
         DV_ITER: begin
            if (!diff[17]) begin
               rem_in = diff[15:0];
               dvd_in = {dvd_ff[30:0], 1'b1};
            end else begin
               rem_in = shifted[15:0];
               dvd_in = {dvd_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = DV_FINAL;
            end
         end
         DV_FINAL: begin
            if (sh_ff[4]) begin
               ratio_in = 32'($signed(v32) >>> rsh);
            end else begin
               ratio_in = v32 << sh_ff;
            end
            done_in  = 1'b1;
            state_in = DV_IDLE;
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   assign status.done  = done_ff;
   assign status.ratio = ratio_ff;

endmodule

[sv/erl_interp.sv]
// Interpolation pipeline: window addressing, weighted products, sum and saturate.
module erl_interp (
   input  logic                               clock,
   input  logic                               reset,
   input  erl_pkg::issue_type                 issue,
   output logic [erl_pkg::ADDR_W-1:0]         rd_addr_a,
   output logic [erl_pkg::ADDR_W-1:0]         rd_addr_b,
   input  logic signed [erl_pkg::VALUE_W-1:0] rd_data_a,
   input  logic signed [erl_pkg::VALUE_W-1:0] rd_data_b,
   output logic                               pipe_busy,
   output logic                               rsp_strobe,
   output erl_pkg::rsp_type                   rsp_payload
);
   import erl_pkg::*;

   logic signed [15:0] idx;
   logic [15:0]        idx_u;
   logic [15:0]        a_pos;
   logic               outside;

   logic               s1_v_ff;
   logic [FRAC_W-1:0]  s1_frac_ff;
   logic [IDX_W-1:0]   s1_index_ff;
   logic               s1_last_ff;

   logic               s2_v_ff;
   logic signed [31:0] s2_pa_ff, s2_pa_in;
   logic signed [31:0] s2_pb_ff, s2_pb_in;
   logic [IDX_W-1:0]   s2_index_ff;
   logic               s2_last_ff;

   logic [FRAC_W-1:0]  weight_a;
   logic signed [32:0] sum;
   logic signed [17:0] scaled;
   logic signed [VALUE_W-1:0] sat;

   logic               rsp_v_ff;
   rsp_type            rsp_ff, rsp_in;

   always_comb begin
      idx     = $signed(issue.acc[31:16]);
      idx_u   = issue.acc[31:16];
      outside = idx[15] || (idx_u >= 16'(WIN_LEN));
      a_pos   = (idx_u == 16'd0) ? 16'd0 : idx_u - 16'd1;
      if (outside || a_pos > 16'(HARMONICS - 1)) begin
         rd_addr_a = LAST_ADDR;
      end else begin
         rd_addr_a = a_pos[ADDR_W-1:0];
      end
      if (outside || idx_u > 16'(HARMONICS - 1)) begin
         rd_addr_b = LAST_ADDR;
      end else begin
         rd_addr_b = idx_u[ADDR_W-1:0];
      end
   end

   always_comb begin
      weight_a = WEIGHT_ONE - s1_frac_ff;
      s2_pa_in = rd_data_a * $signed({1'b0, weight_a});
      s2_pb_in = rd_data_b * $signed({1'b0, s1_frac_ff});
   end

   always_comb begin
      sum    = 33'(s2_pa_ff) + 33'(s2_pb_ff);
      scaled = sum[32:15];
      if (scaled > 18'sd32767) begin
         sat = 16'sh7FFF;
      end else if (scaled < -18'sd32768) begin
         sat = -16'sh8000;
      end else begin
         sat = scaled[15:0];
      end
      rsp_in.out_value = sat;
      rsp_in.out_index = s2_index_ff;
      rsp_in.out_last  = s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= issue.valid;
         s2_v_ff  <= s1_v_ff;
         rsp_v_ff <= s2_v_ff;
      end
      s1_frac_ff  <= issue.acc[15:1];
      s1_index_ff <= issue.index;
      s1_last_ff  <= issue.last;
      s2_pa_ff    <= s2_pa_in;
      s2_pb_ff    <= s2_pb_in;
      s2_index_ff <= s1_index_ff;
      s2_last_ff  <= s1_last_ff;
      rsp_ff      <= rsp_in;
   end

   assign pipe_busy   = s1_v_ff | s2_v_ff;
   assign rsp_strobe  = rsp_v_ff;
   assign rsp_payload = rsp_ff;

endmodule

[sv/erl_checker.sv]
// Port-level checker for the envelope linear resampler, bound to the top level.
module erl_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input erl_pkg::rsp_type rsp_payload,
   input logic             rsp_strobe
);
   import erl_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_strobe && !busy)
      else $error("result or busy right after reset");

   a_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result transfer outside a run");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.out_last |=> !rsp_strobe && !busy)
      else $error("activity after final result");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_payload.out_last |=>
         rsp_strobe && (rsp_payload.out_index == IDX_W'($past(rsp_payload.out_index) + 1'b1)))
      else $error("result index did not advance by one");

endmodule

bind envelope_linear_resampler_top erl_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_payload (rsp_payload),
   .rsp_strobe  (rsp_strobe)
);
